FILE: sv/bbcd_pkg.sv
`timescale 1ns / 1ps
package bbcd_pkg;

    localparam int SLOTS     = 32;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LIM_W     = 9;
    localparam int COUNT_W   = 8;
    localparam int TIME_W    = 32;
    localparam int DEV_W     = 8;
    localparam int BLK_W     = 32;
    localparam int SLOT_W    = 5;
    localparam int STATUS_W  = 2;
    localparam int IN_DATA_W = 80;
    localparam int OUT_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_PIN     = 2'd2,
        KIND_UNPIN   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_BUF    = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef struct packed {
        logic accept;
        logic scan;
        logic commit;
    } t_bbcd_cmd;

    typedef struct packed {
        logic in_read;
        logic scan_done;
        logic out_free;
    } t_bbcd_sts;

endpackage

FILE: sv/bbcd_ctrl.sv
`timescale 1ns / 1ps
module bbcd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bbcd_pkg::t_bbcd_sts i_sts,
    output bbcd_pkg::t_bbcd_cmd o_cmd
);
    import bbcd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.commit = (r_state == S_DONE) && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.in_read ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/bbcd_dp.sv
`timescale 1ns / 1ps
module bbcd_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bbcd_pkg::t_bbcd_cmd           i_cmd,
    output bbcd_pkg::t_bbcd_sts           o_sts,
    input  logic [1:0]                    i_kind,
    input  logic [bbcd_pkg::DEV_W-1:0]    i_device,
    input  logic [bbcd_pkg::BLK_W-1:0]    i_block_number,
    input  logic [bbcd_pkg::SLOT_W-1:0]   i_slot_in,
    input  logic [bbcd_pkg::TIME_W-1:0]   i_now,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bbcd_pkg::SLOT_W-1:0]   o_slot_out,
    output logic                          o_hit,
    output logic                          o_needs_fill,
    output logic [bbcd_pkg::STATUS_W-1:0] o_status
);
    import bbcd_pkg::*;

    logic [DEV_W-1:0]   r_tag_dev  [SLOTS];
    logic [BLK_W-1:0]   r_tag_blk  [SLOTS];
    logic [SLOTS-1:0]   r_in_use;
    logic [COUNT_W-1:0] r_count    [SLOTS];
    logic [TIME_W-1:0]  r_time     [SLOTS];
    logic [SLOTS-1:0]   r_cvalid;

    logic [1:0]         r_kind;
    logic [DEV_W-1:0]   r_dev;
    logic [BLK_W-1:0]   r_blk;
    logic [SLOT_W-1:0]  r_slot;
    logic [TIME_W-1:0]  r_now;

    logic [IDX_W-1:0]   r_idx;
    logic               r_hit_found;
    logic [IDX_W-1:0]   r_hit_idx;
    logic               r_vic_found;
    logic [IDX_W-1:0]   r_vic_idx;
    logic [TIME_W-1:0]  r_vic_time;

    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_slot_out;
    logic               r_hit;
    logic               r_fill;
    logic [STATUS_W-1:0] r_status;

    logic [IDX_W-1:0]   w_cidx;
    logic [IDX_W-1:0]   w_addr;
    logic [DEV_W-1:0]   w_rd_dev;
    logic [BLK_W-1:0]   w_rd_blk;
    logic               w_rd_use;
    logic [COUNT_W-1:0] w_rd_cnt;
    logic [TIME_W-1:0]  w_rd_time;
    logic               w_rd_cv;
    logic               w_match;
    logic               w_last;
    logic               w_slot_ok;

    logic               w_wr_cnt;
    logic [COUNT_W-1:0] w_new_cnt;
    logic               w_wr_time;
    logic               w_retag;
    logic               w_set_cv;
    logic [SLOT_W-1:0]  w_res_slot;
    logic               w_res_hit;
    logic               w_res_fill;
    logic [STATUS_W-1:0] w_res_status;

    assign w_slot_ok = (LIM_W'(r_slot) < LIM_W'(SLOTS));

    always_comb begin
        if (r_kind != KIND_READ) begin
            w_cidx = IDX_W'(r_slot);
        end else if (r_hit_found) begin
            w_cidx = r_hit_idx;
        end else begin
            w_cidx = r_vic_idx;
        end
    end

    assign w_addr    = i_cmd.scan ? r_idx : w_cidx;
    assign w_rd_dev  = r_tag_dev[w_addr];
    assign w_rd_blk  = r_tag_blk[w_addr];
    assign w_rd_use  = r_in_use[w_addr];
    assign w_rd_cnt  = r_count[w_addr];
    assign w_rd_time = r_time[w_addr];
    assign w_rd_cv   = r_cvalid[w_addr];

    assign w_match = w_rd_use && (w_rd_dev == r_dev) && (w_rd_blk == r_blk);
    assign w_last  = (r_idx == IDX_W'(SLOTS - 1));

    assign o_sts.in_read   = (i_kind == KIND_READ);
    assign o_sts.scan_done = w_match || w_last;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        w_wr_cnt     = 1'b0;
        w_new_cnt    = w_rd_cnt;
        w_wr_time    = 1'b0;
        w_retag      = 1'b0;
        w_set_cv     = 1'b0;
        w_res_slot   = r_slot;
        w_res_hit    = 1'b0;
        w_res_fill   = 1'b0;
        w_res_status = ST_OK;
        case (r_kind)
            KIND_READ: begin
                if (r_hit_found) begin
                    w_res_slot = SLOT_W'(r_hit_idx);
                    w_res_hit  = 1'b1;
                    if (w_rd_cnt == COUNT_MAX) begin
                        w_res_status = ST_OVERFLOW;
                    end else begin
                        w_wr_cnt   = 1'b1;
                        w_new_cnt  = w_rd_cnt + 1'b1;
                        w_set_cv   = 1'b1;
                        w_res_fill = !w_rd_cv;
                    end
                end else if (r_vic_found) begin
                    w_res_slot = SLOT_W'(r_vic_idx);
                    w_retag    = 1'b1;
                    w_wr_cnt   = 1'b1;
                    w_new_cnt  = COUNT_W'(1);
                    w_set_cv   = 1'b1;
                    w_res_fill = 1'b1;
                end else begin
                    w_res_slot   = '0;
                    w_res_status = ST_NO_BUF;
                end
            end
            KIND_PIN: begin
                if (w_slot_ok) begin
                    if (w_rd_cnt == COUNT_MAX) begin
                        w_res_status = ST_OVERFLOW;
                    end else begin
                        w_wr_cnt  = 1'b1;
                        w_new_cnt = w_rd_cnt + 1'b1;
                    end
                end
            end
            KIND_RELEASE, KIND_UNPIN: begin
                if (w_slot_ok) begin
                    if (w_rd_cnt == '0) begin
                        w_res_status = ST_UNDERFLOW;
                    end else begin
                        w_wr_cnt  = 1'b1;
                        w_new_cnt = w_rd_cnt - 1'b1;
                        w_wr_time = (r_kind == KIND_RELEASE) && (w_rd_cnt == COUNT_W'(1));
                    end
                end
            end
            default: begin
                w_res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_dev  <= i_device;
            r_blk  <= i_block_number;
            r_slot <= i_slot_in;
            r_now  <= i_now;
        end
        if (i_cmd.scan) begin
            if (w_match && !r_hit_found) begin
                r_hit_idx <= r_idx;
            end
            if (w_rd_cnt == '0 && (!r_vic_found || w_rd_time < r_vic_time)) begin
                r_vic_idx  <= r_idx;
                r_vic_time <= w_rd_time;
            end
        end
        if (i_cmd.commit && w_retag) begin
            r_tag_dev[w_cidx] <= r_dev;
            r_tag_blk[w_cidx] <= r_blk;
        end
        if (i_cmd.commit) begin
            r_slot_out <= w_res_slot;
            r_hit      <= w_res_hit;
            r_fill     <= w_res_fill;
            r_status   <= w_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use    <= '0;
            r_cvalid    <= '0;
            r_idx       <= '0;
            r_hit_found <= 1'b0;
            r_vic_found <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_count[i] <= '0;
                r_time[i]  <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                r_idx       <= '0;
                r_hit_found <= 1'b0;
                r_vic_found <= 1'b0;
            end else if (i_cmd.scan) begin
                r_idx <= r_idx + 1'b1;
                if (w_match) begin
                    r_hit_found <= 1'b1;
                end
                if (w_rd_cnt == '0) begin
                    r_vic_found <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                if (w_wr_cnt) begin
                    r_count[w_cidx] <= w_new_cnt;
                end
                if (w_wr_time) begin
                    r_time[w_cidx] <= r_now;
                end
                if (w_retag) begin
                    r_in_use[w_cidx] <= 1'b1;
                end
                if (w_set_cv) begin
                    r_cvalid[w_cidx] <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot_out   = r_slot_out;
    assign o_hit        = r_hit;
    assign o_needs_fill = r_fill;
    assign o_status     = r_status;

endmodule

FILE: sv/block_buffer_cache_directory.sv
// Buffer cache directory: one request in, one result out.
// Input stream s_axis: tuser carries the request kind (read, release, pin,
// unpin); tdata carries device, block number, slot and the current tick.
// Output stream m_axis: tdata carries the slot, hit, needs-fill flag and
// status of each request, one result per request, in request order.
// A read walks the slots one per cycle looking for a matching tag and the
// oldest unreferenced victim at the same time; it stops at the first hit.
// A read passes through the scan state, then the done state; a miss walks all
// SLOTS slots. Release, pin and unpin go straight to the done state.
// Only one request is in work at a time; the next is accepted the cycle
// after the result is loaded into the output register.
// If m_axis stalls, the finished result waits in the output register and
// the directory holds its update until the register frees up.
// Synchronous active-low reset empties the directory: no tags in use, all
// counts and last-use times zero, no contents valid; no clearing pass.
`timescale 1ns / 1ps
module block_buffer_cache_directory (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] device, [39:8] block_number, [44:40] slot_in, [76:45] now
    input  logic [bbcd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] slot_out, [5] hit, [6] needs_fill, [8:7] status
    output logic [bbcd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import bbcd_pkg::*;

    t_bbcd_cmd           w_cmd;
    t_bbcd_sts           w_sts;
    logic [SLOT_W-1:0]   w_slot_out;
    logic                w_hit;
    logic                w_fill;
    logic [STATUS_W-1:0] w_status;

    bbcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bbcd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_kind         (s_axis_tuser),
        .i_device       (s_axis_tdata[7:0]),
        .i_block_number (s_axis_tdata[39:8]),
        .i_slot_in      (s_axis_tdata[44:40]),
        .i_now          (s_axis_tdata[76:45]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_slot_out     (w_slot_out),
        .o_hit          (w_hit),
        .o_needs_fill   (w_fill),
        .o_status       (w_status)
    );

    assign m_axis_tdata = {7'b0, w_status, w_fill, w_hit, w_slot_out};

endmodule
